// ===== rtl/dted_pkg.sv =====
// ----------------------------------------------------------------------------
// dted_pkg
// Shared types and codes for the elevation data record deframer.
// ----------------------------------------------------------------------------
package dted_pkg;

    // Result kinds, carried on the output tuser.
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_SAMPLE   = 3'd1;
    localparam logic [2:0] KIND_OK       = 3'd2;
    localparam logic [2:0] KIND_BAD_RECOG = 3'd3;
    localparam logic [2:0] KIND_MISMATCH = 3'd4;

    // Configuration register indexes.
    localparam logic REG_SAMPLES_PER_PROFILE = 1'b0;
    localparam logic REG_RECOGNITION_VALUE   = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 152;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [23:0] block_count;
        logic [15:0] column_number;
        logic [15:0] first_index;
        logic [15:0] sample_index;
        logic [15:0] sample_value;
        logic [31:0] checksum_computed;
        logic [31:0] checksum_read;
        logic        end_of_record;
    } result_t;

endpackage

// ===== rtl/dted_parser.sv =====
// ----------------------------------------------------------------------------
// dted_parser
// Record state machine: header capture, sample assembly, byte sum and
// trailer compare. One byte is consumed per enabled cycle.
// ----------------------------------------------------------------------------
module dted_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dted_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic [7:0]                      in_byte,
    input  logic                            in_start,
    output logic                            res_valid,
    output dted_pkg::result_t               res
);

    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_SAMPLES = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    localparam logic [2:0] BLOCK_LAST_POS   = 3'd3;
    localparam logic [2:0] COLUMN_LAST_POS  = 3'd5;
    localparam logic [2:0] HEADER_LAST_POS  = 3'd7;
    localparam logic [2:0] TRAILER_LAST_POS = 3'd3;

    logic [15:0] spp_reg;
    logic [7:0]  recog_reg;

    logic [1:0]  phase_reg,   phase_next;
    logic [2:0]  pos_reg,     pos_next;
    logic [23:0] blocks_reg,  blocks_next;
    logic [15:0] column_reg,  column_next;
    logic [15:0] row_reg,     row_next;
    logic [15:0] index_reg,   index_next;
    logic [7:0]  hold_reg,    hold_next;
    logic [31:0] sum_reg,     sum_next;
    logic [31:0] trailer_reg, trailer_next;

    logic [15:0] index_inc;
    logic [31:0] sum_add;

    assign index_inc = index_reg + 16'd1;
    assign sum_add   = sum_reg + {24'd0, in_byte};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg   <= 16'd3601;
            recog_reg <= 8'd170;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dted_pkg::REG_SAMPLES_PER_PROFILE: spp_reg   <= cfg_data;
                dted_pkg::REG_RECOGNITION_VALUE:   recog_reg <= cfg_data[7:0];
            endcase
        end
    end

    // Next state and the result of the current byte.
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        blocks_next  = blocks_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        index_next   = index_reg;
        hold_next    = hold_reg;
        sum_next     = sum_reg;
        trailer_next = trailer_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (in_valid)
        begin
            if (in_start)
            begin
                // A start flag drops any record; only a matching byte starts one.
                blocks_next  = '0;
                column_next  = '0;
                row_next     = '0;
                trailer_next = '0;
                hold_next    = '0;
                if (in_byte != recog_reg)
                begin
                    phase_next        = PH_WAIT;
                    pos_next          = '0;
                    sum_next          = '0;
                    res_valid         = 1'b1;
                    res.result_kind   = dted_pkg::KIND_BAD_RECOG;
                    res.end_of_record = 1'b1;
                end
                else
                begin
                    phase_next = PH_HEADER;
                    pos_next   = 3'd1;
                    sum_next   = {24'd0, in_byte};
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        // Bytes outside a record are dropped.
                    end
                    PH_HEADER:
                    begin
                        sum_next = sum_add;
                        if (pos_reg <= BLOCK_LAST_POS)
                            blocks_next = {blocks_reg[15:0], in_byte};
                        else if (pos_reg <= COLUMN_LAST_POS)
                            column_next = {column_reg[7:0], in_byte};
                        else
                            row_next = {row_reg[7:0], in_byte};
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg == HEADER_LAST_POS)
                        begin
                            res_valid         = 1'b1;
                            res.result_kind   = dted_pkg::KIND_HEADER;
                            res.block_count   = blocks_next;
                            res.column_number = column_next;
                            res.first_index   = row_next;
                            pos_next          = '0;
                            // A starting row past the profile leaves no samples.
                            if (row_next >= spp_reg)
                            begin
                                phase_next   = PH_TRAILER;
                                trailer_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_SAMPLES;
                                index_next = row_next;
                            end
                        end
                    end
                    PH_SAMPLES:
                    begin
                        sum_next = sum_add;
                        if (pos_reg == 3'd0)
                        begin
                            hold_next = in_byte;
                            pos_next  = 3'd1;
                        end
                        else
                        begin
                            res_valid         = 1'b1;
                            res.result_kind   = dted_pkg::KIND_SAMPLE;
                            res.block_count   = blocks_reg;
                            res.column_number = column_reg;
                            res.first_index   = row_reg;
                            res.sample_index  = index_reg;
                            res.sample_value  = {hold_reg, in_byte};
                            pos_next          = '0;
                            index_next        = index_inc;
                            if ((index_inc == 16'd0) || (index_inc >= spp_reg))
                            begin
                                phase_next   = PH_TRAILER;
                                trailer_next = '0;
                            end
                        end
                    end
                    PH_TRAILER:
                    begin
                        trailer_next = {trailer_reg[23:0], in_byte};
                        pos_next     = pos_reg + 3'd1;
                        if (pos_reg == TRAILER_LAST_POS)
                        begin
                            res_valid             = 1'b1;
                            res.result_kind       = (trailer_next == sum_reg) ?
                                                    dted_pkg::KIND_OK :
                                                    dted_pkg::KIND_MISMATCH;
                            res.block_count       = blocks_reg;
                            res.column_number     = column_reg;
                            res.first_index       = row_reg;
                            res.checksum_computed = sum_reg;
                            res.checksum_read     = trailer_next;
                            res.end_of_record     = 1'b1;
                            phase_next            = PH_WAIT;
                            pos_next              = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            pos_reg     <= '0;
            blocks_reg  <= '0;
            column_reg  <= '0;
            row_reg     <= '0;
            index_reg   <= '0;
            hold_reg    <= '0;
            sum_reg     <= '0;
            trailer_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            blocks_reg  <= blocks_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
            index_reg   <= index_next;
            hold_reg    <= hold_next;
            sum_reg     <= sum_next;
            trailer_reg <= trailer_next;
        end
    end

    // A status result always leaves the parser waiting for a new record.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.end_of_record |=> phase_reg == PH_WAIT)
        else $error("parser not waiting after a record status");

    // Inside the header the position never sits at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> pos_reg != 3'd0)
        else $error("header position at zero");

    // The trailer position stays within the four trailer bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRAILER |-> pos_reg <= TRAILER_LAST_POS)
        else $error("trailer position out of range");

endmodule

// ===== rtl/dted_out_buffer.sv =====
// ----------------------------------------------------------------------------
// dted_out_buffer
// Output register with one skid entry, so the parser keeps taking bytes
// while a result waits for the receiver.
// ----------------------------------------------------------------------------
module dted_out_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  dted_pkg::result_t in_item,
    output logic              in_ready,
    output logic              out_valid,
    output dted_pkg::result_t out_item,
    input  logic              out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    dted_pkg::result_t out_item_reg;
    dted_pkg::result_t skid_item_reg;
    logic              pop;
    logic              load_main;
    logic              load_skid;
    logic              move_skid;

    assign in_ready  = !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;
    assign move_skid = skid_valid_reg && pop;
    assign load_main = in_valid && !skid_valid_reg && (!out_valid_reg || pop);
    assign load_skid = in_valid && !skid_valid_reg && out_valid_reg && !pop;

    // Occupancy of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_main || move_skid)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            if (load_skid)
                skid_valid_reg <= 1'b1;
            else if (move_skid)
                skid_valid_reg <= 1'b0;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge clk)
    begin
        if (move_skid)
            out_item_reg <= skid_item_reg;
        else if (load_main)
            out_item_reg <= in_item;

        if (load_skid)
            skid_item_reg <= in_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The skid entry is only ever filled behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item ahead of the output");

endmodule

// ===== rtl/dted_record_deframer_core.sv =====
// ----------------------------------------------------------------------------
// dted_record_deframer_core
// Elevation data record deframer: one record byte in, header, sample and
// status items out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one record byte per item in s_tdata; s_tuser
//   flags the first byte of a record. The master stream carries one result
//   item: s_tuser-style kind in m_tuser, tlast on the record status, and the
//   header, sample and checksum fields in m_tdata.
//   Registers are written through cfg_we/cfg_index/cfg_data while the block
//   is idle: index 0 samples per profile, index 1 recognition byte.
// Timing:
//   One byte is taken every cycle while the skid entry is free. A byte is
//   held in an input register, then parsed by the record state machine into
//   the output buffer. The byte sum and counters update as each byte is
//   parsed, which sets the rate of one byte per cycle.
// Reset and stall:
//   Reset restores the register defaults and waits for a start flag. When the
//   receiver stalls, one more result is held in a skid entry; after that the
//   input stops taking bytes until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module dted_record_deframer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dted_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tuser,  // [0] start_of_record
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [23:0] block_count, [39:24] column_number, [55:40] first_index,
    // [71:56] sample_index, [87:72] sample_value, [119:88] checksum_computed,
    // [151:120] checksum_read
    output logic [dted_pkg::TDATA_W-1:0]    m_tdata,
    output logic [2:0]                      m_tuser,  // [2:0] result_kind
    output logic                            m_tlast   // end_of_record
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              buf_ready;
    logic              fire;
    logic              res_valid;
    dted_pkg::result_t res;
    dted_pkg::result_t out_item;

    assign fire     = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || buf_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    dted_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (fire),
        .in_byte   (in_byte_reg),
        .in_start  (in_start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dted_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fire && res_valid),
        .in_item   (res),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .out_ready (m_tready)
    );

    // Pack the result item onto the master stream.
    assign m_tdata = {out_item.checksum_read,
                      out_item.checksum_computed,
                      out_item.sample_value,
                      out_item.sample_index,
                      out_item.first_index,
                      out_item.column_number,
                      out_item.block_count};
    assign m_tuser = out_item.result_kind;
    assign m_tlast = out_item.end_of_record;

endmodule
